[rtl/core/strmin_pkg.sv]
// strmin_pkg: sizes, command and status codes, controller states and
// the command/status structs shared by the sparse table modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package strmin_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;
    localparam int VAL_W        = 64;
    localparam int POS_W        = 10;   // width of the left/right fields
    localparam int CNT_W        = 11;   // element count width
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int LVL_W        = $clog2(LEVELS);
    localparam int DEPTH        = LEVELS * MAX_ELEMENTS;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int SUM_W        = ((CNT_W > LEVELS) ? CNT_W : LEVELS) + 1;
    localparam int LOG_W        = $clog2(SUM_W);
    localparam int IN_DATA_W    = 88;   // value, left, right, zero padded
    localparam int OUT_DATA_W   = 64;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_QREAD,
        S_QCMP,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    load_in;     // latch the accepted request
        logic    app_step;    // write one level of an append
        logic    q_read;      // issue both query reads
        logic    q_cmp;       // combine query read data into result
        logic    clear;       // empty the table
        logic    res_load;    // load a result with zero minimum
        t_status res_status;
        logic    load_out;    // move result into output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic app_last;
        logic q_bad;
    } t_dp_stat;

    function automatic logic [VAL_W-1:0] smin(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
        smin = ($signed(b) < $signed(a)) ? b : a;
    endfunction

    // index of the highest set bit, zero for zero
    function automatic logic [LOG_W-1:0] floor_log2(input logic [SUM_W-1:0] x);
        logic [LOG_W-1:0] k;
        k = '0;
        for (int i = 1; i < SUM_W; i++) begin
            if (x[i]) begin
                k = LOG_W'(i);
            end
        end
        floor_log2 = k;
    endfunction

    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [IDX_W-1:0] idx);
        tbl_addr = ADDR_W'(lvl) * ADDR_W'(MAX_ELEMENTS) + ADDR_W'(idx);
    endfunction

endpackage

`default_nettype wire

[rtl/core/strmin_dp.sv]
// strmin_dp: level table memory, element count, append and query datapath,
// result and output data registers
// depends on strmin_pkg
`timescale 1ns / 1ps
`default_nettype none

module strmin_dp import strmin_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire t_dp_cmd         i_cmd,
    input  wire [IN_DATA_W-1:0]  i_data,
    output t_dp_stat             o_stat,
    output wire [OUT_DATA_W-1:0] o_out_data,
    output wire [1:0]            o_out_user
);

    logic [VAL_W-1:0]  r_mem [DEPTH];

    logic [CNT_W-1:0]  r_cnt;
    logic [VAL_W-1:0]  r_cur;
    logic [POS_W-1:0]  r_left;
    logic [POS_W-1:0]  r_right;
    logic [LVL_W-1:0]  r_lvl;
    logic [LVL_W-1:0]  r_jmax;
    logic [VAL_W-1:0]  r_rd_a;
    logic [VAL_W-1:0]  r_rd_b;
    logic [1:0]        r_res_status;
    logic [VAL_W-1:0]  r_res_min;
    logic [1:0]        r_out_user;
    logic [VAL_W-1:0]  r_out_data;

    logic [SUM_W-1:0]  pos_next;     // count + 1
    logic [LOG_W-1:0]  log_next;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [SUM_W-1:0]  start_cur;
    logic [SUM_W-1:0]  start_nxt;
    logic [SUM_W-1:0]  q_len;
    logic [LOG_W-1:0]  q_k;
    logic [SUM_W-1:0]  q_second;

    assign pos_next = SUM_W'(r_cnt) + SUM_W'(1);
    assign log_next = floor_log2(pos_next);

    // append: block of level j that ends at the new element
    assign start_cur = pos_next - (SUM_W'(1) << r_lvl);
    assign start_nxt = pos_next - (SUM_W'(1) << (SUM_W'(r_lvl) + SUM_W'(1)));
    assign wdata     = (r_lvl == '0) ? r_cur : smin(r_cur, r_rd_a);
    assign waddr     = tbl_addr(r_lvl, start_cur[IDX_W-1:0]);

    // query: two overlapping blocks of size 2^k
    assign q_len    = SUM_W'(r_right) - SUM_W'(r_left) + SUM_W'(1);
    assign q_k      = floor_log2(q_len);
    assign q_second = SUM_W'(r_right) + SUM_W'(1) - (SUM_W'(1) << q_k);

    always_comb begin
        if (i_cmd.q_read) begin
            raddr_a = tbl_addr(q_k[LVL_W-1:0], r_left[IDX_W-1:0]);
        end else begin
            raddr_a = tbl_addr(r_lvl, start_nxt[IDX_W-1:0]);
        end
        raddr_b = tbl_addr(q_k[LVL_W-1:0], q_second[IDX_W-1:0]);
    end

    assign o_stat.full     = (r_cnt >= CNT_W'(MAX_ELEMENTS));
    assign o_stat.app_last = (r_lvl == r_jmax);
    assign o_stat.q_bad    = (r_left > r_right) || (CNT_W'(r_right) >= r_cnt)
                             || (q_k >= LOG_W'(LEVELS));

    // table memory, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.app_step) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_a <= r_mem[raddr_a];
        r_rd_b <= r_mem[raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_cnt <= '0;
        end else if (i_cmd.app_step && o_stat.app_last) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cur   <= i_data[VAL_W-1:0];
            r_left  <= i_data[VAL_W +: POS_W];
            r_right <= i_data[VAL_W+POS_W +: POS_W];
            r_lvl   <= '0;
            if (log_next >= LOG_W'(LEVELS - 1)) begin
                r_jmax <= LVL_W'(LEVELS - 1);
            end else begin
                r_jmax <= log_next[LVL_W-1:0];
            end
        end else if (i_cmd.app_step) begin
            r_cur <= wdata;
            r_lvl <= r_lvl + LVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_min    <= '0;
        end else if (i_cmd.q_cmp) begin
            r_res_status <= ST_OK;
            r_res_min    <= smin(r_rd_a, r_rd_b);
        end
        if (i_cmd.load_out) begin
            r_out_user <= r_res_status;
            r_out_data <= r_res_min;
        end
    end

    assign o_out_data = r_out_data;
    assign o_out_user = r_out_user;

endmodule

`default_nettype wire

[rtl/core/strmin_ctrl.sv]
// strmin_ctrl: request sequencer and output valid register
// depends on strmin_pkg
`timescale 1ns / 1ps
`default_nettype none

module strmin_ctrl import strmin_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_s_tvalid,
    input  wire [1:0] i_s_tuser,
    output logic      o_s_tready,
    output wire       o_m_tvalid,
    input  wire       i_m_tready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.res_status = ST_OK;
        o_s_tready = (r_state == S_IDLE);
        accept     = i_s_tvalid && o_s_tready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_in = 1'b1;
                    case (t_cmd'(i_s_tuser))
                        CMD_APPEND: begin
                            if (i_stat.full) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_FULL;
                                n_state          = S_EMIT;
                            end else begin
                                o_cmd.res_load = 1'b1;
                                n_state        = S_APPEND;
                            end
                        end
                        CMD_QUERY: begin
                            n_state = S_QREAD;
                        end
                        CMD_CLEAR: begin
                            o_cmd.clear    = 1'b1;
                            o_cmd.res_load = 1'b1;
                            n_state        = S_EMIT;
                        end
                        default: begin
                            o_cmd.res_load = 1'b1;
                            n_state        = S_EMIT;
                        end
                    endcase
                end
            end
            S_APPEND: begin
                o_cmd.app_step = 1'b1;
                if (i_stat.app_last) begin
                    n_state = S_EMIT;
                end
            end
            S_QREAD: begin
                if (i_stat.q_bad) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_RANGE;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.q_read = 1'b1;
                    n_state      = S_QCMP;
                end
            end
            S_QCMP: begin
                o_cmd.q_cmp = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

[rtl/core/sparse_table_range_min.sv]
// sparse_table_range_min: top level of the incremental range-minimum
// sparse table; joins the sequencer and the datapath
// depends on strmin_pkg, strmin_ctrl, strmin_dp
//
// channel   direction  handshake              payload
// s (req)   in         i_s_tvalid/o_s_tready  tuser: cmd; tdata: value, left, right
// m (res)   out        o_m_tvalid/i_m_tready  tuser: status; tdata: minimum
//
// one request at a time; the input is ready only while the sequencer idles
// append: accept, then one table level written per step (up to 11 levels,
//   one memory write port), then the move to the output register
// query: accept, read both blocks, compare, output; a bad range skips read and compare
// clear, full append, unused code: accept, then output
// a held result does not block the next request; a new result waits for it
// reset clears the count and control; the table holds no reset value
`timescale 1ns / 1ps
`default_nettype none

module sparse_table_range_min import strmin_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output wire                   o_s_tready,
    input  wire [IN_DATA_W-1:0]   i_s_tdata,   // value[63:0], left[73:64], right[83:74]
    input  wire [1:0]             i_s_tuser,   // cmd[1:0]
    output wire                   o_m_tvalid,
    input  wire                   i_m_tready,
    output wire [OUT_DATA_W-1:0]  o_m_tdata,   // minimum[63:0]
    output wire [1:0]             o_m_tuser    // status[1:0]
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: walks append levels and query steps
    strmin_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // table memory, count and result registers
    strmin_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_data     (i_s_tdata),
        .o_stat     (dp_stat),
        .o_out_data (o_m_tdata),
        .o_out_user (o_m_tuser)
    );

endmodule

`default_nettype wire

[test/sparse_table_range_min_tb.sv]
// sparse_table_range_min_tb: self-checking testbench for the incremental
// range-minimum sparse table, with its own table mirror and random traffic
// depends on strmin_pkg and sparse_table_range_min
`timescale 1ns / 1ps

module sparse_table_range_min_tb;
    import strmin_pkg::*;

    localparam int IDLE_LIMIT = 5000;  // cycles with no handshake on either side
    localparam int LONG_HOLD  = 400;   // receiver hold-off, in cycles
    localparam int TAIL       = 40;    // quiet cycles after the last result
    localparam int PAD_W      = IN_DATA_W - VAL_W - 2 * POS_W;

    typedef struct {
        t_status         status;
        logic [VAL_W-1:0] minimum;
    } t_result;

    typedef enum int {
        RX_OPEN,      // always ready
        RX_COIN,      // ready half the time
        RX_SPARSE,    // ready with probability one in four
        RX_PERIODIC   // fixed ready/stall rhythm
    } t_rx_mode;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    wire                   s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [1:0]            s_tuser  = CMD_NONE;
    wire                   m_tvalid;
    logic                  m_tready = 1'b0;
    wire  [OUT_DATA_W-1:0] m_tdata;
    wire  [1:0]            m_tuser;

    sparse_table_range_min uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // value[63:0], left[73:64], right[83:74]
        .i_s_tuser  (s_tuser),   // cmd[1:0]
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // minimum[63:0]
        .o_m_tuser  (m_tuser)    // status[1:0]
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mirror of the table and the element count
    logic [VAL_W-1:0] level_mirror [LEVELS][MAX_ELEMENTS];
    int               elem_count = 0;
    t_result          awaited_results [$];
    int               fails = 0;

    // sender burst shaping
    int burst_left = 1;

    // receiver stall control
    int       hold_requests = 0;
    int       holds_done    = 0;
    int       hold_left     = 0;
    t_rx_mode rx_mode       = RX_OPEN;
    int       rx_mode_left  = 0;
    int       rx_phase      = 0;

    function automatic logic [VAL_W-1:0] lesser(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
        return ($signed(b) < $signed(a)) ? b : a;
    endfunction

    // apply one request to the mirror and give the result it must produce
    function automatic t_result step_sparse_table(input t_cmd cmd,
                                                  input logic [VAL_W-1:0] value,
                                                  input logic [POS_W-1:0] left,
                                                  input logic [POS_W-1:0] right);
        t_result res;
        int      p;
        int      j;
        int      start;
        int      len;
        int      k;
        res.status  = ST_OK;
        res.minimum = '0;
        case (cmd)
            CMD_APPEND: begin
                if (elem_count >= MAX_ELEMENTS) begin
                    res.status = ST_FULL;
                end else begin
                    p = elem_count;
                    level_mirror[0][p] = value;
                    // every level block that ends at the new element
                    for (j = 1; j < LEVELS && (1 << j) <= p + 1; j++) begin
                        start = p + 1 - (1 << j);
                        level_mirror[j][start] =
                            lesser(level_mirror[j-1][start],
                                   level_mirror[j-1][start + (1 << (j - 1))]);
                    end
                    elem_count = p + 1;
                end
            end
            CMD_QUERY: begin
                if (left > right || int'(right) >= elem_count) begin
                    res.status = ST_RANGE;
                end else begin
                    len = int'(right) - int'(left) + 1;
                    k = 0;
                    while ((len >> (k + 1)) != 0) k++;
                    if (k >= LEVELS) begin
                        res.status = ST_RANGE;
                    end else begin
                        res.minimum = lesser(level_mirror[k][left],
                                             level_mirror[k][int'(right) + 1 - (1 << k)]);
                    end
                end
            end
            CMD_CLEAR: begin
                elem_count = 0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // element values weighted toward extremes, ties and sign changes
    function automatic logic [VAL_W-1:0] pick_value();
        logic [31:0]      r;
        logic [VAL_W-1:0] v;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       v = {1'b0, {(VAL_W-1){1'b1}}};
            1:       v = {1'b1, {(VAL_W-1){1'b0}}};
            2:       v = {{(VAL_W-4){r[3]}}, r[3:0]};
            3:       v = {VAL_W{r[0]}};
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // offer one request, wait for acceptance, then maybe leave a gap
    task automatic send_req(input t_cmd cmd, input logic [VAL_W-1:0] value,
                            input logic [POS_W-1:0] left, input logic [POS_W-1:0] right);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{PAD_W{1'b0}}, right, left, value};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        awaited_results.push_back(step_sparse_table(cmd, value, left, right));
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
            repeat (gap) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic send_append();
        send_req(CMD_APPEND, pick_value(), POS_W'($urandom), POS_W'($urandom));
    endtask

    // a query inside the stored elements; caller makes sure one exists
    task automatic send_valid_query();
        int l;
        int r;
        int len;
        int k;
        case ($urandom_range(0, 3))
            0: begin
                l = $urandom_range(0, elem_count - 1);
                r = l;
            end
            1: begin
                // lengths at and just below a power of two
                k = 0;
                while ((2 << k) <= elem_count) k++;
                k = $urandom_range(0, k);
                len = 1 << k;
                if (len > 1 && $urandom_range(0, 1)) len--;
                l = $urandom_range(0, elem_count - len);
                r = l + len - 1;
            end
            default: begin
                l = $urandom_range(0, elem_count - 1);
                r = $urandom_range(l, elem_count - 1);
            end
        endcase
        send_req(CMD_QUERY, {$urandom, $urandom}, POS_W'(l), POS_W'(r));
    endtask

    task automatic send_bad_query();
        int l;
        int r;
        case ($urandom_range(0, 2))
            0: begin
                l = $urandom_range(1, MAX_ELEMENTS - 1);
                r = $urandom_range(0, l - 1);
            end
            1: begin
                r = (elem_count < MAX_ELEMENTS) ? $urandom_range(elem_count, MAX_ELEMENTS - 1)
                                                : $urandom_range(0, MAX_ELEMENTS - 1);
                l = $urandom_range(0, r);
            end
            default: begin
                l = $urandom_range(0, MAX_ELEMENTS - 1);
                r = $urandom_range(0, MAX_ELEMENTS - 1);
            end
        endcase
        send_req(CMD_QUERY, {$urandom, $urandom}, POS_W'(l), POS_W'(r));
    endtask

    // stop offering and wait for every pending result
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        logic [VAL_W-1:0] vmax;
        logic [VAL_W-1:0] vmin;
        vmax = {1'b0, {(VAL_W-1){1'b1}}};
        vmin = {1'b1, {(VAL_W-1){1'b0}}};
        send_req(CMD_QUERY, '0, 10'd0, 10'd0);              // query on empty table
        send_req(CMD_CLEAR, '0, 10'd0, 10'd0);              // clear when empty
        send_req(CMD_NONE, '1, 10'h3ff, 10'h3ff);           // unused code, all ones
        send_req(CMD_APPEND, vmax, 10'h3ff, 10'h3ff);
        send_req(CMD_APPEND, vmin, 10'd0, 10'd0);
        send_req(CMD_APPEND, '1, 10'd0, 10'd0);
        send_req(CMD_APPEND, '0, 10'd0, 10'd0);
        send_req(CMD_APPEND, 64'd1, 10'd0, 10'd0);
        send_req(CMD_QUERY, '0, 10'd0, 10'd0);
        send_req(CMD_QUERY, '0, 10'd0, 10'd1);
        send_req(CMD_QUERY, '0, 10'd2, 10'd4);
        send_req(CMD_QUERY, '1, 10'd0, 10'd4);              // every stored element
        send_req(CMD_QUERY, '0, 10'd3, 10'd4);
        send_req(CMD_QUERY, '0, 10'd4, 10'd3);              // left above right
        send_req(CMD_QUERY, '0, 10'd0, 10'd5);              // right past the count
        send_req(CMD_QUERY, '0, 10'h3ff, 10'h3ff);
        send_req(CMD_NONE, vmin, 10'd1, 10'd2);             // must leave the table alone
        send_req(CMD_QUERY, '0, 10'd1, 10'd4);
        send_req(CMD_CLEAR, '1, 10'h3ff, 10'h3ff);
        send_req(CMD_QUERY, '0, 10'd0, 10'd0);              // stale contents not visible
        send_req(CMD_APPEND, 64'd5, 10'd0, 10'd0);
        send_req(CMD_QUERY, '0, 10'd0, 10'd0);
        send_req(CMD_APPEND, 64'd5, 10'd0, 10'd0);          // tie
        send_req(CMD_QUERY, '0, 10'd0, 10'd1);
    endtask

    // fill to capacity while the receiver is held off for a long stretch
    task automatic test_fill_to_capacity();
        send_req(CMD_CLEAR, '0, 10'd0, 10'd0);
        hold_requests++;
        while (elem_count < MAX_ELEMENTS) begin
            if (elem_count > 0 && $urandom_range(0, 99) < 15) begin
                send_valid_query();
            end else begin
                send_append();
            end
        end
        repeat (4) send_append();                            // table full
        send_req(CMD_QUERY, '0, 10'd0, 10'd1023);            // needs the top level
        send_req(CMD_QUERY, '0, 10'd1, 10'd1023);
        send_req(CMD_QUERY, '0, 10'd0, 10'd511);
        send_req(CMD_QUERY, '0, 10'd512, 10'd1023);
        send_req(CMD_QUERY, '0, 10'd1023, 10'd1023);
        repeat (60) send_valid_query();
        repeat (5) send_bad_query();
        send_req(CMD_NONE, {$urandom, $urandom}, POS_W'($urandom), POS_W'($urandom));
        send_req(CMD_QUERY, '0, 10'd0, 10'd1023);
        send_req(CMD_CLEAR, '0, 10'd0, 10'd0);
        send_req(CMD_QUERY, '0, 10'd0, 10'd0);
    endtask

    // mixed traffic on small tables with clears in between
    task automatic test_random_traffic();
        int sel;
        repeat (450) begin
            sel = $urandom_range(0, 99);
            if (elem_count >= 300 && sel < 20) begin
                send_req(CMD_CLEAR, {$urandom, $urandom}, POS_W'($urandom), POS_W'($urandom));
            end else if (sel < 52 || (elem_count == 0 && sel < 85)) begin
                send_append();
            end else if (sel < 85) begin
                send_valid_query();
            end else if (sel < 92) begin
                send_bad_query();
            end else if (sel < 96) begin
                send_req(CMD_CLEAR, {$urandom, $urandom}, POS_W'($urandom), POS_W'($urandom));
            end else begin
                send_req(CMD_NONE, {$urandom, $urandom}, POS_W'($urandom), POS_W'($urandom));
            end
        end
    endtask

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(negedge clk) begin
        if (holds_done != hold_requests) begin
            if (hold_left == 0) hold_left = LONG_HOLD;
            hold_left--;
            if (hold_left == 0) holds_done++;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(30, 200);
            end
            rx_mode_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN:     m_tready <= 1'b1;
                RX_COIN:     m_tready <= $urandom_range(0, 1);
                RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                default:     m_tready <= ((rx_phase % 11) < 4);
            endcase
        end
    end

    // result checker
    always @(posedge clk) begin : check_results
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: status %0d minimum %0d", m_tuser, $signed(m_tdata));
                fails++;
            end else begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
                    fails++;
                end
                if (m_tdata !== want.minimum) begin
                    $error("minimum mismatch: expected %0d, got %0d",
                           $signed(want.minimum), $signed(m_tdata));
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin : watchdog
        int idle_cycles;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        wait_drained();
        test_fill_to_capacity();
        wait_drained();
        test_random_traffic();
        wait_drained();

        repeat (TAIL) @(posedge clk);
        if (fails == 0 && awaited_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
